FILE: rtl/core/bitmap_page_allocator_refcount_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_REFCOUNT_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_REFCOUNT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, quiet while reset is asserted.
`define BAPR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, quiet while reset is asserted.
`define BAPR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
// Next-cycle implication that is also checked around reset.
`define BAPR_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BAPR_ASSERT_IMP(lbl, ante, cons, msg)
`define BAPR_ASSERT_NXT(lbl, ante, cons, msg)
`define BAPR_ASSERT_RST(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/bapr_pkg.sv
// ----------------------------------------------------------------------------
// bapr_pkg
// Shared types and constants of the page allocator.
// ----------------------------------------------------------------------------
package bapr_pkg;

    localparam int NUM_PAGES_DEFAULT = 4096;
    localparam int PAGE_SHIFT        = 12;
    localparam int PAGE_BYTES        = 4096;
    localparam int ADDR_W            = 32;
    localparam int CMD_W             = 3;
    localparam int CNT_W             = 8;
    localparam int FREE_W            = 13;
    localparam int CFG_W             = 32;
    localparam int CFG_IDX_W         = 2;
    localparam int WORD_BITS         = 32;
    localparam int ROW_CNT_W         = CNT_W * WORD_BITS;

    localparam logic [WORD_BITS-1:0] ALL_USED  = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]     COUNT_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_FREE_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_BASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_LEN   = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 3'd0,
        CMD_ALLOC = 3'd1,
        CMD_FREE  = 3'd2,
        CMD_REF   = 3'd3,
        CMD_QUERY = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_ALLOC,
        S_UPDATE,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] rel_base;
        logic [CFG_W-1:0] rel_len;
        logic [CFG_W-1:0] rsv_base;
        logic [CFG_W-1:0] rsv_len;
    } cfg_t;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] page_address;
        logic [CNT_W-1:0]  reference_count;
        logic [FREE_W-1:0] free_count;
    } res_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

FILE: rtl/core/bitmap_page_allocator_refcount.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_refcount
// Physical page allocator with a used bitmap and 8-bit reference counts.
// ----------------------------------------------------------------------------
// Commands are taken one at a time. The used bits sit in a RAM of 32-bit
// words and the counts in a second RAM whose rows hold the 32 counts of the
// same word, so every command works through one word per cycle on a single
// read and a single write port. With W = ceil(NUM_PAGES/32) words (128 by
// default): init sweeps all W words, allocate scans them for a free page,
// free and add reference update the addressed word and query reads it; an
// address beyond the pages or an undefined command touches no word. After
// reset a clearing pass over all W words runs before the first command is
// taken; configuration writes are accepted throughout. A finished result
// waits in the output register while the next command is already taken.
`include "bitmap_page_allocator_refcount_macros.svh"

module bitmap_page_allocator_refcount #(
    parameter int NUM_PAGES = bapr_pkg::NUM_PAGES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] address
    input  logic [2:0]  s_tuser,   // [2:0] command
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] page_address, [39:32] reference_count,
                                   // [52:40] free_count, [55:53] zero
    output logic [0:0]  m_tuser,   // [0] status
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int PGW   = $clog2(NUM_PAGES);
    localparam int WW    = PGW - 5;
    localparam int WORDS = (NUM_PAGES + 31) / 32;

    bapr_pkg::cfg_t     cfg_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [55:0]        m_tdata_reg, m_tdata_next;
    logic [0:0]         m_tuser_reg, m_tuser_next;

    logic               out_free;
    logic               res_valid;
    bapr_pkg::res_t     res;
    logic               map_load;
    logic [WW-1:0]      map_word;
    logic [31:0]        map_used;
    bapr_pkg::mem_ctl_t mem_ctl;
    logic [WW-1:0]      rd_addr, wr_addr;
    logic [31:0]        used_rdata, used_wdata;
    logic [bapr_pkg::ROW_CNT_W-1:0] cnt_rdata, cnt_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                bapr_pkg::CFG_FREE_BASE: cfg_reg.rel_base <= cfg_wdata;
                bapr_pkg::CFG_FREE_LEN:  cfg_reg.rel_len  <= cfg_wdata;
                bapr_pkg::CFG_RSV_BASE:  cfg_reg.rsv_base <= cfg_wdata;
                bapr_pkg::CFG_RSV_LEN:   cfg_reg.rsv_len  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bapr_map #(
        .NUM_PAGES (NUM_PAGES)
    ) u_map (
        .aclk      (aclk),
        .load      (map_load),
        .cfg       (cfg_reg),
        .word      (map_word),
        .used_word (map_used)
    );

    bapr_ctrl #(
        .NUM_PAGES (NUM_PAGES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_addr    (s_tdata),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .map_load   (map_load),
        .map_word   (map_word),
        .map_used   (map_used),
        .mem_ctl    (mem_ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .used_rdata (used_rdata),
        .used_wdata (used_wdata),
        .cnt_rdata  (cnt_rdata),
        .cnt_wdata  (cnt_wdata)
    );

    bapr_ram #(
        .WIDTH (bapr_pkg::WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WW)
    ) u_used_ram (
        .aclk    (aclk),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (used_rdata),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (used_wdata)
    );

    bapr_ram #(
        .WIDTH (bapr_pkg::ROW_CNT_W),
        .DEPTH (WORDS),
        .AW    (WW)
    ) u_cnt_ram (
        .aclk    (aclk),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (cnt_rdata),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (cnt_wdata)
    );

    // The output register is free when empty or when its transfer completes now.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, res.free_count, res.reference_count, res.page_address};
            m_tuser_next  = res.status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `BAPR_ASSERT_RST(a_clear_after_reset, !aresetn, !s_tready, "command taken during clearing pass")
    `BAPR_ASSERT_IMP(a_accept_no_result, s_tvalid && s_tready, !res_valid, "result while idle")
    `BAPR_ASSERT_NXT(a_result_loaded, res_valid, m_tvalid, "result not presented")
    `BAPR_ASSERT_IMP(a_oom_zero_addr, m_tvalid && m_tuser[0], m_tdata[31:0] == 32'd0, "bad oom address")

endmodule

FILE: rtl/core/bapr_ram.sv
// ----------------------------------------------------------------------------
// bapr_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bapr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/bapr_map.sv
// ----------------------------------------------------------------------------
// bapr_map
// Builds the used-bit word of each bitmap word for an init sweep.
// ----------------------------------------------------------------------------
module bapr_map #(
    parameter int NUM_PAGES = bapr_pkg::NUM_PAGES_DEFAULT,
    parameter int PGW       = $clog2(NUM_PAGES),
    parameter int WW        = PGW - 5
) (
    input  logic                               aclk,
    input  logic                               load,
    input  bapr_pkg::cfg_t                     cfg,
    input  logic [WW-1:0]                      word,
    output logic [bapr_pkg::WORD_BITS-1:0]     used_word
);

    // Page bounds must also hold NUM_PAGES itself.
    localparam int BW = PGW + 1;
    localparam logic [21:0] LIMIT = 22'(NUM_PAGES);

    logic [BW-1:0] free_lo_reg, free_hi_reg, rsv_lo_reg, rsv_hi_reg;
    logic          rsv_on_reg;
    logic [32:0]   free_sum;
    logic [33:0]   rsv_sum;
    logic [bapr_pkg::WORD_BITS-1:0] free_mask, rsv_mask;

    function automatic logic [BW-1:0] clip(input logic [21:0] pg);
        logic [BW-1:0] r;
        r = (pg > LIMIT) ? BW'(NUM_PAGES) : pg[BW-1:0];
        return r;
    endfunction

    // Pages of this word that lie in [lo, hi).
    function automatic logic [bapr_pkg::WORD_BITS-1:0] span_mask(
        input logic [WW-1:0] w, input logic [BW-1:0] lo, input logic [BW-1:0] hi);
        logic [WW:0] wx;
        logic [bapr_pkg::WORD_BITS-1:0] ge, lt;
        wx = {1'b0, w};
        if (wx > lo[BW-1:5]) begin
            ge = bapr_pkg::ALL_USED;
        end else if (wx == lo[BW-1:5]) begin
            ge = bapr_pkg::ALL_USED << lo[4:0];
        end else begin
            ge = '0;
        end
        if (wx < hi[BW-1:5]) begin
            lt = bapr_pkg::ALL_USED;
        end else if (wx == hi[BW-1:5]) begin
            lt = ~(bapr_pkg::ALL_USED << hi[4:0]);
        end else begin
            lt = '0;
        end
        return ge & lt;
    endfunction

    assign free_sum = {1'b0, cfg.rel_base} + {1'b0, cfg.rel_len};
    assign rsv_sum  = {2'b00, cfg.rsv_base} + {2'b00, cfg.rsv_len}
                    + 34'(bapr_pkg::PAGE_BYTES - 1);

    always_ff @(posedge aclk) begin
        if (load) begin
            free_lo_reg <= clip({2'b00, cfg.rel_base[31:12]});
            free_hi_reg <= clip({1'b0, free_sum[32:12]});
            rsv_lo_reg  <= clip({2'b00, cfg.rsv_base[31:12]});
            rsv_hi_reg  <= clip(rsv_sum[33:12]);
            rsv_on_reg  <= (cfg.rsv_len != '0);
        end
    end

    always_comb begin
        free_mask = span_mask(word, free_lo_reg, free_hi_reg);
        rsv_mask  = rsv_on_reg ? span_mask(word, rsv_lo_reg, rsv_hi_reg) : '0;
        // Page 0 is always held back.
        if (word == '0) begin
            rsv_mask[0] = 1'b1;
        end
        used_word = ~(free_mask & ~rsv_mask);
    end

endmodule

FILE: rtl/core/bapr_ctrl.sv
// ----------------------------------------------------------------------------
// bapr_ctrl
// Command sequencer: sweeps, scans and read-modify-writes of the two RAMs.
// ----------------------------------------------------------------------------
module bapr_ctrl #(
    parameter int NUM_PAGES = bapr_pkg::NUM_PAGES_DEFAULT,
    parameter int PGW       = $clog2(NUM_PAGES),
    parameter int WW        = PGW - 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bapr_pkg::CMD_W-1:0]          in_cmd,
    input  logic [bapr_pkg::ADDR_W-1:0]         in_addr,
    input  logic                                out_free,
    output logic                                res_valid,
    output bapr_pkg::res_t                      res,
    output logic                                map_load,
    output logic [WW-1:0]                       map_word,
    input  logic [bapr_pkg::WORD_BITS-1:0]      map_used,
    output bapr_pkg::mem_ctl_t                  mem_ctl,
    output logic [WW-1:0]                       rd_addr,
    output logic [WW-1:0]                       wr_addr,
    input  logic [bapr_pkg::WORD_BITS-1:0]      used_rdata,
    output logic [bapr_pkg::WORD_BITS-1:0]      used_wdata,
    input  logic [bapr_pkg::ROW_CNT_W-1:0]      cnt_rdata,
    output logic [bapr_pkg::ROW_CNT_W-1:0]      cnt_wdata
);

    localparam int WORDS = (NUM_PAGES + 31) / 32;
    localparam int SW    = WW + 1;
    localparam logic [SW-1:0] LAST_WORD  = SW'(WORDS - 1);
    localparam logic [SW-1:0] WORDS_DONE = SW'(WORDS);
    localparam logic [20:0]   PAGE_LIMIT = 21'(NUM_PAGES);

    bapr_pkg::state_t state_reg, state_next;
    logic [SW-1:0]    word_reg, word_next;
    logic             pend_reg, pend_next;
    logic [WW-1:0]    pend_word_reg, pend_word_next;
    logic [4:0]       bit_reg, bit_next;
    bapr_pkg::cmd_t   cmd_reg, cmd_next;
    bapr_pkg::res_t   res_reg, res_next;
    logic [bapr_pkg::FREE_W-1:0] free_reg, free_next;

    logic [PGW-1:0]             in_page;
    logic                       in_range;
    logic                       found;
    logic [4:0]                 zero_bit;
    logic                       used_bit;
    logic [bapr_pkg::CNT_W-1:0] cnt_cur;
    logic [7:0]                 byte_sel;

    function automatic logic [4:0] first_zero(input logic [bapr_pkg::WORD_BITS-1:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = bapr_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    assign in_page  = in_addr[bapr_pkg::PAGE_SHIFT +: PGW];
    assign in_range = {1'b0, in_addr[31:12]} < PAGE_LIMIT;
    assign found    = pend_reg && (used_rdata != bapr_pkg::ALL_USED);
    assign zero_bit = first_zero(used_rdata);
    assign used_bit = used_rdata[bit_reg];
    assign byte_sel = {bit_reg, 3'b000};
    assign cnt_cur  = cnt_rdata[byte_sel +: bapr_pkg::CNT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bapr_pkg::S_CLEAR;
            word_reg  <= '0;
            pend_reg  <= 1'b0;
            free_reg  <= '0;
        end else begin
            state_reg <= state_next;
            word_reg  <= word_next;
            pend_reg  <= pend_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_word_reg <= pend_word_next;
        bit_reg       <= bit_next;
        cmd_reg       <= cmd_next;
        res_reg       <= res_next;
    end

    always_comb begin
        state_next     = state_reg;
        word_next      = word_reg;
        pend_next      = pend_reg;
        pend_word_next = pend_word_reg;
        bit_next       = bit_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        free_next      = free_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        map_load       = 1'b0;
        map_word       = word_reg[WW-1:0];
        mem_ctl        = '0;
        rd_addr        = word_reg[WW-1:0];
        wr_addr        = pend_word_reg;
        used_wdata     = used_rdata;
        cnt_wdata      = cnt_rdata;

        case (state_reg)
            bapr_pkg::S_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = word_reg[WW-1:0];
                used_wdata    = bapr_pkg::ALL_USED;
                cnt_wdata     = '0;
                word_next     = word_reg + 1'b1;
                if (word_reg == LAST_WORD) begin
                    word_next  = '0;
                    state_next = bapr_pkg::S_IDLE;
                end
            end
            bapr_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_next       = '0;
                    pend_word_next = in_page[PGW-1:5];
                    bit_next       = in_page[4:0];
                    cmd_next       = bapr_pkg::cmd_t'(in_cmd);
                    rd_addr        = in_page[PGW-1:5];
                    case (bapr_pkg::cmd_t'(in_cmd))
                        bapr_pkg::CMD_INIT: begin
                            map_load   = 1'b1;
                            word_next  = '0;
                            free_next  = '0;
                            state_next = bapr_pkg::S_INIT;
                        end
                        bapr_pkg::CMD_ALLOC: begin
                            word_next  = '0;
                            pend_next  = 1'b0;
                            state_next = bapr_pkg::S_ALLOC;
                        end
                        bapr_pkg::CMD_FREE, bapr_pkg::CMD_REF, bapr_pkg::CMD_QUERY: begin
                            if (in_range) begin
                                mem_ctl.rd_en = 1'b1;
                                state_next    = bapr_pkg::S_UPDATE;
                            end else begin
                                state_next = bapr_pkg::S_REPLY;
                            end
                        end
                        default: begin
                            state_next = bapr_pkg::S_REPLY;
                        end
                    endcase
                end
            end
            bapr_pkg::S_INIT: begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = word_reg[WW-1:0];
                used_wdata    = map_used;
                cnt_wdata     = '0;
                free_next     = free_reg + bapr_pkg::FREE_W'(6'd32 - 6'($countones(map_used)));
                word_next     = word_reg + 1'b1;
                if (word_reg == LAST_WORD) begin
                    state_next = bapr_pkg::S_REPLY;
                end
            end
            bapr_pkg::S_ALLOC: begin
                // One word is read per cycle; the previous word's data is checked meanwhile.
                if (found) begin
                    mem_ctl.wr_en = 1'b1;
                    used_wdata    = used_rdata | (32'd1 << zero_bit);
                    cnt_wdata[{zero_bit, 3'b000} +: bapr_pkg::CNT_W] = 8'd1;
                    free_next     = free_reg - 1'b1;
                    res_next.page_address =
                        bapr_pkg::ADDR_W'({pend_word_reg, zero_bit}) << bapr_pkg::PAGE_SHIFT;
                    state_next    = bapr_pkg::S_REPLY;
                end else if (word_reg == WORDS_DONE) begin
                    res_next.status = 1'b1;
                    state_next      = bapr_pkg::S_REPLY;
                end else begin
                    mem_ctl.rd_en  = 1'b1;
                    pend_next      = 1'b1;
                    pend_word_next = word_reg[WW-1:0];
                    word_next      = word_reg + 1'b1;
                end
            end
            bapr_pkg::S_UPDATE: begin
                state_next = bapr_pkg::S_REPLY;
                case (cmd_reg)
                    bapr_pkg::CMD_FREE: begin
                        if (used_bit) begin
                            mem_ctl.wr_en = 1'b1;
                            if (cnt_cur > 8'd1) begin
                                cnt_wdata[byte_sel +: bapr_pkg::CNT_W] = cnt_cur - 1'b1;
                            end else begin
                                cnt_wdata[byte_sel +: bapr_pkg::CNT_W] = '0;
                                used_wdata[bit_reg] = 1'b0;
                                free_next = free_reg + 1'b1;
                            end
                        end
                    end
                    bapr_pkg::CMD_REF: begin
                        if (used_bit && (cnt_cur != bapr_pkg::COUNT_MAX)) begin
                            mem_ctl.wr_en = 1'b1;
                            cnt_wdata[byte_sel +: bapr_pkg::CNT_W] = cnt_cur + 1'b1;
                        end
                    end
                    bapr_pkg::CMD_QUERY: begin
                        res_next.reference_count = cnt_cur;
                    end
                    default: begin
                    end
                endcase
            end
            bapr_pkg::S_REPLY: begin
                res_valid = out_free;
                if (out_free) begin
                    state_next = bapr_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bapr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        res            = res_reg;
        res.free_count = free_reg;
    end

endmodule
